/* rtl/core/hbcd_pkg.sv */
// Shared types, constants and helpers of the HTTP body chunk decoder.
// No dependencies; imported by every module of the block.
package hbcd_pkg;

	localparam int LEN_BITS = 32;	// width of chunk size and remaining count
	localparam int CNT_BITS = 32;	// payload byte counter, wraps
	localparam int REG_BITS = 32;	// configuration data width
	localparam int ADDR_BITS = 3;	// two registers at byte addresses 0 and 4

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	// register indexes (paddr[2])
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_LEN  = 1'b1;

	typedef enum logic [6:0] {
		PH_SIZE   = 7'b0000001,
		PH_SIZELF = 7'b0000010,
		PH_DATA   = 7'b0000100,
		PH_CR     = 7'b0001000,
		PH_LF     = 7'b0010000,
		PH_DONE   = 7'b0100000,
		PH_ERROR  = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_SIZE = 2'd1,
		ERR_CRLF = 2'd2,
		ERR_OVF  = 2'd3
	} err_t;

	typedef struct packed {
		logic                chunked_mode;
		logic [REG_BITS-1:0] body_length;
	} cfg_t;

	typedef struct packed {
		phase_t              phase;
		logic [LEN_BITS-1:0] size_acc;
		logic                digit_seen;
		logic [LEN_BITS-1:0] remaining;
		logic [CNT_BITS-1:0] received;
		err_t                err;
	} dec_state_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       body_done;
		logic       leftover;
		logic       error_flag;
		err_t       error_code;
	} result_t;

	// {is_hex, value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic dec_state_t clear_state();
		dec_state_t s;
		s.phase      = PH_SIZE;
		s.size_acc   = '0;
		s.digit_seen = 1'b0;
		s.remaining  = '0;
		s.received   = '0;
		s.err        = ERR_NONE;
		return s;
	endfunction

endpackage

/* rtl/core/hbcd_regs.sv */
// Configuration registers of the body decoder behind an APB-style port.
// Depends on hbcd_pkg.
module hbcd_regs
	import hbcd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [REG_BITS-1:0]  pwdata,
	output logic [REG_BITS-1:0]  prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	logic                chunked_mode_q;
	logic [REG_BITS-1:0] body_length_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_mode_q <= 1'b0;
			body_length_q  <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MODE: chunked_mode_q <= pwdata[0];
				REG_LEN:  body_length_q  <= pwdata;
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = {{(REG_BITS-1){1'b0}}, chunked_mode_q};
			REG_LEN:  prdata = body_length_q;
			default:  prdata = '0;
		endcase
	end

	assign cfg.chunked_mode = chunked_mode_q;
	assign cfg.body_length  = body_length_q;

endmodule

/* rtl/core/hbcd_step.sv */
// Next-state and result logic for one body byte.
// Depends on hbcd_pkg.
module hbcd_step
	import hbcd_pkg::*;
(
	input  cfg_t       cfg,
	input  dec_state_t cur,
	input  logic [7:0] data_byte,
	input  logic       restart,
	output dec_state_t nxt,
	output result_t    res
);

	dec_state_t          s;
	logic                pay;
	logic                left;
	logic [4:0]          hv;
	logic [CNT_BITS-1:0] rcv_inc;
	logic [LEN_BITS-1:0] rem_dec;

	always_comb begin
		s       = restart ? clear_state() : cur;
		nxt     = s;
		pay     = 1'b0;
		left    = 1'b0;
		hv      = hex_value(data_byte);
		rcv_inc = s.received + 1'b1;
		rem_dec = s.remaining - 1'b1;

		if (s.phase == PH_ERROR) begin
			// bytes after an error are dropped
		end else if (s.phase == PH_DONE) begin
			left = 1'b1;
		end else if (!cfg.chunked_mode) begin
			if (s.received >= cfg.body_length) begin
				nxt.phase = PH_DONE;
				left      = 1'b1;
			end else begin
				pay          = 1'b1;
				nxt.received = rcv_inc;
				if (rcv_inc >= cfg.body_length)
					nxt.phase = PH_DONE;
			end
		end else begin
			unique case (s.phase)
				PH_SIZE: begin
					if (data_byte == CH_CR) begin
						nxt.phase = PH_SIZELF;
					end else if (!hv[4]) begin
						nxt.phase = PH_ERROR;
						nxt.err   = ERR_SIZE;
					end else if (s.size_acc[LEN_BITS-1 -: 4] != 4'd0) begin
						nxt.phase = PH_ERROR;
						nxt.err   = ERR_OVF;
					end else begin
						nxt.size_acc   = {s.size_acc[LEN_BITS-5:0], hv[3:0]};
						nxt.digit_seen = 1'b1;
					end
				end
				PH_SIZELF: begin
					if (data_byte != CH_LF || !s.digit_seen) begin
						nxt.phase = PH_ERROR;
						nxt.err   = ERR_SIZE;
					end else if (s.size_acc == '0) begin
						nxt.phase = PH_DONE;
					end else begin
						nxt.remaining = s.size_acc;
						nxt.phase     = PH_DATA;
					end
				end
				PH_DATA: begin
					pay           = 1'b1;
					nxt.received  = rcv_inc;
					nxt.remaining = rem_dec;
					if (rem_dec == '0)
						nxt.phase = PH_CR;
				end
				PH_CR: begin
					if (data_byte == CH_CR) begin
						nxt.phase = PH_LF;
					end else begin
						nxt.phase = PH_ERROR;
						nxt.err   = ERR_CRLF;
					end
				end
				PH_LF: begin
					if (data_byte == CH_LF) begin
						nxt.phase      = PH_SIZE;
						nxt.size_acc   = '0;
						nxt.digit_seen = 1'b0;
					end else begin
						nxt.phase = PH_ERROR;
						nxt.err   = ERR_CRLF;
					end
				end
				default: begin
					nxt.phase = PH_ERROR;
					nxt.err   = ERR_SIZE;
				end
			endcase
		end

		res.payload_byte  = pay ? data_byte : 8'd0;
		res.payload_valid = pay;
		res.body_done     = (nxt.phase == PH_DONE);
		res.leftover      = left;
		res.error_flag    = (nxt.err != ERR_NONE);
		res.error_code    = nxt.err;
	end

endmodule

/* rtl/core/http_body_chunk_decoder.sv */
// Top level of the HTTP/1.1 body decoder: stream ports, APB registers,
// input and result registers. Depends on hbcd_pkg, hbcd_regs, hbcd_step.
//
// Usage:
//  - Slave stream: one raw body byte per transfer in s_tdata; s_tuser
//    carries restart, which clears the decoder before that byte.
//  - Master stream: exactly one result per input byte, in order. m_tdata
//    holds the payload byte (zero when not payload), m_tuser the flags.
//  - Registers: chunked_mode at 0x0, body_length at 0x4; write them only
//    while no byte is in flight.
//  - Pipeline: one input register, one result register. A byte moves from
//    the input register into the result register when the latter is empty
//    or being taken. Throughput: one byte per cycle while m_tready stays
//    high; the combinational decode step between the registers sets it.
//  - Stall: the input register advances whenever the result register is
//    empty or being taken, so s_tready drops only while both hold data
//    and m_tready is low. Nothing is lost or repeated across a stall.
//  - Reset: both pipeline slots empty, decoder in size-line start,
//    counters and error cleared, registers at zero (fixed length, 0 bytes).
//  - Errors are sticky until a byte with restart set arrives.
module http_body_chunk_decoder
	import hbcd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,	// [7:0] data_byte
	input  logic                 s_tuser,	// [0] restart
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,	// [7:0] payload_byte
	output logic [5:0]           m_tuser,	// [0] payload_valid, [1] body_done,
						// [2] leftover, [3] error_flag, [5:4] error_code
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [REG_BITS-1:0]  pwdata,
	output logic [REG_BITS-1:0]  prdata,
	output logic                 pready
);

	cfg_t       cfg;
	dec_state_t state_q;
	dec_state_t state_nxt;
	result_t    res;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;
	logic       valid_s2;
	logic [7:0] tdata_s2;
	logic [5:0] tuser_s2;

	logic adv_s1;	// s1 item moves into the result register this cycle
	logic take_in;

	hbcd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hbcd_step u_step (
		.cfg       (cfg),
		.cur       (state_q),
		.data_byte (byte_s1),
		.restart   (restart_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	assign adv_s1   = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | adv_s1;
	assign take_in  = s_tvalid & s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1    <= s_tdata;
			restart_s1 <= s_tuser;
		end
	end

	// decoder state commits as the item leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clear_state();
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tdata_s2 <= res.payload_byte;
			tuser_s2 <= {res.error_code, res.error_flag, res.leftover,
				res.body_done, res.payload_valid};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = tdata_s2;
	assign m_tuser  = tuser_s2;

	// error flag always agrees with a non-zero code
	a_err_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[3] == (m_tuser[5:4] != 2'd0)))
		else $error("error_flag disagrees with error_code");

	// a byte is never both payload and leftover
	a_pay_left: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[2]))
		else $error("payload and leftover both set");

	// leftover only once the body has ended
	a_left_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> m_tuser[1])
		else $error("leftover without body_done");

	// error phase always carries a stored code
	a_err_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_ERROR) |-> (state_q.err != ERR_NONE))
		else $error("error phase without error code");

endmodule
